// ===== sv/assert_macros.svh =====
// Assertion macros for the checker file of the project.
// Depends on nothing; a file includes it before its module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/xtea_pkg.sv =====
// Package of the XTEA cipher: beat types, stage record, constants and the mix function.
// Depends on nothing; every module of the block imports it.
package xtea_pkg;

  // Default number of rounds and the key schedule constant.
  localparam int          XteaRounds = 32;
  localparam logic [31:0] XteaDelta  = 32'h9E37_79B9;

  // Direction codes carried in the func field.
  localparam logic FuncEncrypt = 1'b0;
  localparam logic FuncDecrypt = 1'b1;

  // Input beat.
  typedef struct packed {
    logic        func;
    logic [31:0] block_word0;
    logic [31:0] block_word1;
    logic [31:0] key_word0;
    logic [31:0] key_word1;
    logic [31:0] key_word2;
    logic [31:0] key_word3;
  } xtea_in_t;

  // Result beat.
  typedef struct packed {
    logic [31:0] out_word0;
    logic [31:0] out_word1;
  } xtea_out_t;

  // Record that travels from cell to cell along the chain.
  typedef struct packed {
    logic            func;
    logic [31:0]     v0;
    logic [31:0]     v1;
    logic [31:0]     sum;
    logic [3:0][31:0] key;
  } xtea_stage_t;

  // The shift, xor and add applied to one word in each half-round.
  function automatic logic [31:0] xtea_mix(input logic [31:0] v);
    return ((v << 4) ^ (v >> 5)) + v;
  endfunction

endpackage

// ===== sv/xtea_block_cipher.sv =====
// Channel  | Ports                          | Beat
// ---------+--------------------------------+------------------------------------------
// input    | in_valid, in_stall, in_data    | func, two block words, four key words
// result   | out_valid, out_stall, out_data | two result words
//
// One beat is taken every cycle while in_stall is low; a result leaves through the chain
// of ROUNDS round cells with two register stages each and then through the output
// register. Reset clears the valid flags of the cells and the output.
// A stalled result holds the output register; the next result goes to the skid
// entry, and only while that entry is full are the chain and in_stall held.
// Top level of the XTEA cipher; depends on xtea_pkg, xtea_round_cell and xtea_out_skid.
module xtea_block_cipher #(
  parameter int ROUNDS = xtea_pkg::XteaRounds
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  xtea_pkg::xtea_in_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output xtea_pkg::xtea_out_t out_data
);
  import xtea_pkg::*;

  // Deciphering starts from delta times the round count, modulo 2^32.
  localparam logic [63:0] SumWide    = 64'(XteaDelta) * 64'(ROUNDS);
  localparam logic [31:0] SumDecrypt = SumWide[31:0];

  logic        advance;
  logic        chain_valid [ROUNDS+1];
  xtea_stage_t chain_stage [ROUNDS+1];
  xtea_out_t   last_data;

  // Entry of the chain: the beat as a stage record with its starting sum.
  assign chain_valid[0] = in_valid;
  assign chain_stage[0] = '{
    func: in_data.func,
    v0:   in_data.block_word0,
    v1:   in_data.block_word1,
    sum:  (in_data.func == FuncDecrypt) ? SumDecrypt : 32'd0,
    key:  {in_data.key_word3, in_data.key_word2, in_data.key_word1, in_data.key_word0}
  };

  // The row of round cells.
  for (genvar g = 0; g < ROUNDS; g++) begin : g_round
    xtea_round_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (advance),
      .in_valid  (chain_valid[g]),
      .in_stage  (chain_stage[g]),
      .out_valid (chain_valid[g+1]),
      .out_stage (chain_stage[g+1])
    );
  end

  assign last_data.out_word0 = chain_stage[ROUNDS].v0;
  assign last_data.out_word1 = chain_stage[ROUNDS].v1;

  // Output register and skid entry.
  xtea_out_skid u_out_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .p_valid   (chain_valid[ROUNDS]),
    .p_data    (last_data),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign in_stall = !advance;

endmodule

// ===== sv/xtea_round_cell.sv =====
// One XTEA round as a cell of the chain: two half-rounds, each closed by a register.
// Depends on xtea_pkg for the stage record, the constants and the mix function.
module xtea_round_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  xtea_pkg::xtea_stage_t in_stage,
  output logic                 out_valid,
  output xtea_pkg::xtea_stage_t out_stage
);
  import xtea_pkg::*;

  logic        half_valid_r;
  xtea_stage_t half_r;
  xtea_stage_t half_nxt;
  logic        full_valid_r;
  xtea_stage_t full_r;
  xtea_stage_t full_nxt;

  logic [31:0] mix_a;
  logic [31:0] keyed_a;
  logic [31:0] mix_b;
  logic [31:0] keyed_b;

  // First half-round: enciphering updates v0 and steps the sum up,
  // deciphering updates v1 and steps the sum down.
  always_comb begin
    half_nxt = in_stage;
    if (in_stage.func == FuncDecrypt) begin
      mix_a        = xtea_mix(in_stage.v0);
      keyed_a      = in_stage.sum + in_stage.key[in_stage.sum[12:11]];
      half_nxt.v1  = in_stage.v1 - (mix_a ^ keyed_a);
      half_nxt.sum = in_stage.sum - XteaDelta;
    end else begin
      mix_a        = xtea_mix(in_stage.v1);
      keyed_a      = in_stage.sum + in_stage.key[in_stage.sum[1:0]];
      half_nxt.v0  = in_stage.v0 + (mix_a ^ keyed_a);
      half_nxt.sum = in_stage.sum + XteaDelta;
    end
  end

  // Second half-round works on the other word with the stepped sum.
  always_comb begin
    full_nxt = half_r;
    if (half_r.func == FuncDecrypt) begin
      mix_b       = xtea_mix(half_r.v1);
      keyed_b     = half_r.sum + half_r.key[half_r.sum[1:0]];
      full_nxt.v0 = half_r.v0 - (mix_b ^ keyed_b);
    end else begin
      mix_b       = xtea_mix(half_r.v0);
      keyed_b     = half_r.sum + half_r.key[half_r.sum[12:11]];
      full_nxt.v1 = half_r.v1 + (mix_b ^ keyed_b);
    end
  end

  // Valid flags are reset; the data registers only move with the chain.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_valid_r <= 1'b0;
      full_valid_r <= 1'b0;
    end else if (en) begin
      half_valid_r <= in_valid;
      full_valid_r <= half_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      half_r <= half_nxt;
      full_r <= full_nxt;
    end
  end

  assign out_valid = full_valid_r;
  assign out_stage = full_r;

endmodule

// ===== sv/xtea_out_skid.sv =====
// Output register with a skid entry that parts the cell chain from the result channel.
// Depends on xtea_pkg for the result beat type.
module xtea_out_skid (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                p_valid,
  input  xtea_pkg::xtea_out_t p_data,
  output logic                advance,
  output logic                out_valid,
  input  logic                out_stall,
  output xtea_pkg::xtea_out_t out_data
);
  import xtea_pkg::*;

  logic      out_valid_r;
  logic      out_valid_nxt;
  xtea_out_t out_data_r;
  xtea_out_t out_data_nxt;
  logic      skid_valid_r;
  logic      skid_valid_nxt;
  xtea_out_t skid_data_r;
  xtea_out_t skid_data_nxt;
  logic      pop;
  logic      push;

  // The chain moves only while the skid entry is free.
  assign advance = !skid_valid_r;
  assign pop     = out_valid_r && !out_stall;
  assign push    = p_valid && !skid_valid_r;

  // Next values of the output register and the skid entry.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = p_data;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = p_data;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/xtea_checker.sv =====
// Port-level checks of the XTEA cipher and the bind that attaches them.
// Depends on assert_macros.svh, xtea_pkg and the top level xtea_block_cipher.
`include "assert_macros.svh"

module xtea_port_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input xtea_pkg::xtea_out_t out_data
);
  import xtea_pkg::*;

  // A stalled result beat stays offered and unchanged.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_data))

  // The input side is held only while a result waits in the output register.
  `ASSERT_IMPLY(a_stall_needs_result, clk, rst_n, in_stall, out_valid)

  // The input side is held only after a result beat was refused.
  `ASSERT_IMPLY(a_stall_cause, clk, rst_n, $rose(in_stall), $past(out_valid && out_stall))

endmodule

bind xtea_block_cipher xtea_port_checker u_xtea_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
